// ===== hw/rtl/isc_pkg.sv =====
// ============================================================================
// isc_pkg : shared types and constants for the checkerboard ising core
// transaction payloads, operation and register codes, reset values
// ============================================================================
package isc_pkg;

    localparam int SIDE_DEF  = 32;     // default lattice edge length
    localparam int SITE_W    = 10;     // site index field width
    localparam int RND_W     = 16;     // random fraction / acceptance level width
    localparam int MAG_OUT_W = 12;     // magnetization field width
    localparam int CFG_W     = 16;     // config write data width

    localparam logic [RND_W-1:0] ACCEPT_LEVEL_4_RST = 16'd11245;
    localparam logic [RND_W-1:0] ACCEPT_LEVEL_8_RST = 16'd1929;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic {
        CFG_ACCEPT_LEVEL_4 = 1'b0,
        CFG_ACCEPT_LEVEL_8 = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_op               op;
        logic [RND_W-1:0]  rnd;
        logic [SITE_W-1:0] read_site;
    } t_in_item;

    typedef struct packed {
        logic [SITE_W-1:0]          site_index;
        logic                       spin;
        logic                       flipped;
        logic                       last_of_sweep;
        logic signed [MAG_OUT_W-1:0] magnet_sum;
    } t_out_item;

endpackage

// ===== hw/rtl/ising_checkerboard_metropolis_core.sv =====
// ============================================================================
// ising_checkerboard_metropolis_core : 2d ising lattice, checkerboard sweep
// metropolis updates and site reads on a SIDE x SIDE periodic spin lattice
// ============================================================================
//
// input channel (valid/ready) carries one transaction per item: op selects a
// sweep update (rnd is the acceptance random fraction) or a site read
// (read_site). the output channel (valid/ready) returns exactly one result
// transaction per item, in order.
// config port: a write with i_cfg_we loads accept_level_4 (index 0) or
// accept_level_8 (index 1); do it only while no transaction is in flight.
// an accepted item is registered in the working stage, then its result in
// the output register, which drives o_out_valid. throughput: one item per
// cycle unless the output stalls; the row memory reads three rows at the
// accept edge, the flip decision and row write-back fit in the working stage.
// reset: the lattice comes up as a checkerboard (even sites +1) at once, via
// per-row valid bits; no clearing pass, items are accepted right after reset.
// sweep restarts at the first even site, magnetization is the reset sum.
// stall: a result waits in the output register; one more item is still taken
// into the working stage, after which input ready drops until the output
// drains.
//
module ising_checkerboard_metropolis_core
    import isc_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input transactions
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    // result transactions
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    // configuration writes
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int ROW_W    = $clog2(SIDE);
    localparam int SITES    = SIDE * SIDE;
    localparam int MAG_W    = $clog2(SITES + 1) + 1;
    // reciprocal of SIDE, exact for every 10-bit read_site
    localparam int RECIP_SH = 20;
    localparam int RECIP    = (2 ** RECIP_SH + SIDE - 1) / SIDE;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int QP_W     = SITE_W + RECIP_W;
    localparam int PRD_W    = SITE_W + $clog2(SIDE + 1);

    // configuration
    logic [RND_W-1:0] r_lvl4, r_lvl8;

    // handshake
    logic in_acc;
    logic upd_acc;
    logic s1_adv;

    // sweep position
    logic [ROW_W-1:0] sw_row, sw_col;
    logic             sw_last;

    // read address split
    logic [QP_W-1:0]   q_prod;
    logic [SITE_W-1:0] rd_q;
    logic              rd_in_range;
    logic [ROW_W-1:0]  rd_row;

    // working stage
    logic              r_s1_valid;
    t_op               r_s1_op;
    logic [RND_W-1:0]  r_s1_rnd;
    logic [SITE_W-1:0] r_s1_base;      // sweep row or read quotient
    logic [ROW_W-1:0]  r_s1_col;
    logic              r_s1_last;
    logic              r_s1_in_range;
    logic [SITE_W-1:0] r_s1_read_site;

    logic [SIDE-1:0]   ctr_word, up_word, dn_word;
    logic              spin_old, flip;
    logic [SIDE-1:0]   new_word;
    logic [PRD_W-1:0]  base_prod;
    logic [PRD_W-1:0]  upd_idx;
    logic [ROW_W-1:0]  read_col;
    logic              s1_update;

    logic signed [MAG_W-1:0] r_magnet, n_magnet;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data, n_out_data;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl4 <= ACCEPT_LEVEL_4_RST;
            r_lvl8 <= ACCEPT_LEVEL_8_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACCEPT_LEVEL_4: r_lvl4 <= i_cfg_wdata;
                CFG_ACCEPT_LEVEL_8: r_lvl8 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------- handshake
    // working stage moves on when the output register is free or draining
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign upd_acc    = in_acc && (i_in_data.op == OP_UPDATE);

    // ---------------------------------------------------------- sweep order
    isc_sweep_ctr #(.SIDE(SIDE)) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (upd_acc),
        .o_row   (sw_row),
        .o_col   (sw_col),
        .o_last  (sw_last)
    );

    // --------------------------------------------------------- read address
    assign q_prod      = QP_W'(i_in_data.read_site) * QP_W'(RECIP);
    assign rd_q        = SITE_W'(q_prod >> RECIP_SH);
    assign rd_in_range = (32'(i_in_data.read_site) < 32'(SITES));
    // out-of-lattice reads fetch row 0 and report spin 0
    assign rd_row      = rd_in_range ? ROW_W'(rd_q) : '0;

    // ------------------------------------------------------------ row store
    isc_row_store #(.SIDE(SIDE)) u_rows (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_acc),
        .i_rd_row   ((i_in_data.op == OP_UPDATE) ? sw_row : rd_row),
        .i_wr_en    (s1_adv && s1_update),
        .i_wr_row   (ROW_W'(r_s1_base)),
        .i_wr_data  (new_word),
        .o_ctr_word (ctr_word),
        .o_up_word  (up_word),
        .o_dn_word  (dn_word)
    );

    // --------------------------------------------------------- working stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op        <= i_in_data.op;
            r_s1_rnd       <= i_in_data.rnd;
            r_s1_base      <= (i_in_data.op == OP_UPDATE) ? SITE_W'(sw_row) : rd_q;
            r_s1_col       <= sw_col;
            r_s1_last      <= sw_last;
            r_s1_in_range  <= rd_in_range;
            r_s1_read_site <= i_in_data.read_site;
        end
    end

    assign s1_update = (r_s1_op == OP_UPDATE);

    isc_flip_unit #(.SIDE(SIDE)) u_flip (
        .i_ctr_word (ctr_word),
        .i_up_word  (up_word),
        .i_dn_word  (dn_word),
        .i_col      (r_s1_col),
        .i_rnd      (r_s1_rnd),
        .i_lvl4     (r_lvl4),
        .i_lvl8     (r_lvl8),
        .o_spin_old (spin_old),
        .o_flip     (flip),
        .o_new_word (new_word)
    );

    // row * SIDE serves both the update index and the read column
    assign base_prod = PRD_W'(r_s1_base) * PRD_W'(SIDE);
    assign upd_idx   = base_prod + PRD_W'(r_s1_col);
    assign read_col  = ROW_W'(PRD_W'(r_s1_read_site) - base_prod);

    // magnetization: a flip of +1 gives -2, a flip of -1 gives +2
    always_comb begin
        n_magnet = r_magnet;
        if (s1_update && flip) begin
            n_magnet = spin_old ? (r_magnet - MAG_W'(2)) : (r_magnet + MAG_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magnet <= MAG_W'(SIDE % 2);
        end else if (s1_adv) begin
            r_magnet <= n_magnet;
        end
    end

    always_comb begin
        n_out_data.magnet_sum = MAG_OUT_W'(n_magnet);
        if (s1_update) begin
            n_out_data.site_index    = SITE_W'(upd_idx);
            n_out_data.spin          = spin_old ^ flip;
            n_out_data.flipped       = flip;
            n_out_data.last_of_sweep = r_s1_last;
        end else begin
            n_out_data.site_index    = r_s1_read_site;
            n_out_data.spin          = r_s1_in_range ? ctr_word[read_col] : 1'b0;
            n_out_data.flipped       = 1'b0;
            n_out_data.last_of_sweep = 1'b0;
        end
    end

    // -------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------ assertions
    a_magnet_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_magnet[0] == 1'(SIDE % 2))
        else $error("magnetization parity broken");

    a_read_keeps_magnet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_op == OP_READ) |=> $stable(r_magnet))
        else $error("site read changed magnetization");

    a_result_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_s1_valid))
        else $error("result appeared without a working item");

endmodule

// ===== hw/rtl/isc_sweep_ctr.sv =====
// ============================================================================
// isc_sweep_ctr : checkerboard sweep position
// walks even-parity sites row by row, then odd-parity sites, then wraps
// ============================================================================
module isc_sweep_ctr
    import isc_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    output logic [$clog2(SIDE)-1:0]  o_row,
    output logic [$clog2(SIDE)-1:0]  o_col,
    output logic                     o_last
);

    localparam int HALF  = SIDE / 2;
    localparam int ROW_W = $clog2(SIDE);
    localparam int K_W   = (HALF > 1) ? $clog2(HALF) : 1;

    logic             r_pass, n_pass;
    logic [ROW_W-1:0] r_row, n_row;
    logic [K_W-1:0]   r_k, n_k;
    logic             row_end;
    logic             k_end;

    assign row_end = (r_row == ROW_W'(SIDE - 1));
    assign k_end   = (r_k == K_W'(HALF - 1));
    assign o_last  = r_pass && row_end && k_end;
    assign o_row   = r_row;
    // column: parity offset of this row in this pass, then every second site
    assign o_col   = ROW_W'({r_k, (r_row[0] ^ r_pass)});

    always_comb begin
        n_pass = r_pass;
        n_row  = r_row;
        n_k    = r_k;
        if (i_adv) begin
            if (k_end) begin
                n_k = '0;
                if (row_end) begin
                    n_row  = '0;
                    n_pass = ~r_pass;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_k = r_k + K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= 1'b0;
            r_row  <= '0;
            r_k    <= '0;
        end else begin
            r_pass <= n_pass;
            r_row  <= n_row;
            r_k    <= n_k;
        end
    end

    a_wrap_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_last) |=> (o_row == '0 && o_col == '0 && !r_pass))
        else $error("sweep did not restart at first even site");

endmodule

// ===== hw/rtl/isc_row_store.sv =====
// ============================================================================
// isc_row_store : lattice storage as one word per row
// two copies of the row memory give center, up and down rows at one read edge;
// rows never written read as the checkerboard reset pattern
// ============================================================================
module isc_row_store
    import isc_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(SIDE)-1:0]  i_rd_row,
    input  logic                     i_wr_en,
    input  logic [$clog2(SIDE)-1:0]  i_wr_row,
    input  logic [SIDE-1:0]          i_wr_data,
    output logic [SIDE-1:0]          o_ctr_word,
    output logic [SIDE-1:0]          o_up_word,
    output logic [SIDE-1:0]          o_dn_word
);

    localparam int ROW_W = $clog2(SIDE);

    // copy a serves the vertical neighbors, copy b the center row
    logic [SIDE-1:0]  r_mem_a [SIDE];
    logic [SIDE-1:0]  r_mem_b [SIDE];
    logic [SIDE-1:0]  r_row_vld;

    logic [ROW_W-1:0] up_row;
    logic [ROW_W-1:0] dn_row;

    logic [SIDE-1:0]  r_ctr_raw, r_up_raw, r_dn_raw;
    logic [SIDE-1:0]  r_fwd_word;
    logic             r_ctr_fwd, r_up_fwd, r_dn_fwd;
    logic             r_ctr_vld, r_up_vld, r_dn_vld;
    logic             r_ctr_par, r_up_par, r_dn_par;

    function automatic logic [SIDE-1:0] reset_row(input logic par);
        logic [SIDE-1:0] w;
        for (int c = 0; c < SIDE; c++) begin
            w[c] = ~(par ^ c[0]);
        end
        return w;
    endfunction

    assign up_row = (i_rd_row == '0) ? ROW_W'(SIDE - 1) : i_rd_row - ROW_W'(1);
    assign dn_row = (i_rd_row == ROW_W'(SIDE - 1)) ? '0 : i_rd_row + ROW_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_a[i_wr_row] <= i_wr_data;
            r_mem_b[i_wr_row] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_ctr_raw <= r_mem_b[i_rd_row];
            r_up_raw  <= r_mem_a[up_row];
            r_dn_raw  <= r_mem_a[dn_row];
        end
    end

    // write-through: a row written at the read edge comes from the write data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_word <= i_wr_data;
            r_ctr_fwd  <= i_wr_en && (i_wr_row == i_rd_row);
            r_up_fwd   <= i_wr_en && (i_wr_row == up_row);
            r_dn_fwd   <= i_wr_en && (i_wr_row == dn_row);
            r_ctr_vld  <= r_row_vld[i_rd_row];
            r_up_vld   <= r_row_vld[up_row];
            r_dn_vld   <= r_row_vld[dn_row];
            r_ctr_par  <= i_rd_row[0];
            r_up_par   <= up_row[0];
            r_dn_par   <= dn_row[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (i_wr_en) begin
            r_row_vld[i_wr_row] <= 1'b1;
        end
    end

    assign o_ctr_word = r_ctr_fwd ? r_fwd_word :
                        (r_ctr_vld ? r_ctr_raw : reset_row(r_ctr_par));
    assign o_up_word  = r_up_fwd ? r_fwd_word :
                        (r_up_vld ? r_up_raw : reset_row(r_up_par));
    assign o_dn_word  = r_dn_fwd ? r_fwd_word :
                        (r_dn_vld ? r_dn_raw : reset_row(r_dn_par));

    a_row_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |=> r_row_vld[$past(i_wr_row)])
        else $error("written row not marked valid");

endmodule

// ===== hw/rtl/isc_flip_unit.sv =====
// ============================================================================
// isc_flip_unit : metropolis decision for one site
// counts aligned neighbors, applies the acceptance test, patches the row
// ============================================================================
module isc_flip_unit
    import isc_pkg::*;
#(
    parameter int SIDE = SIDE_DEF
) (
    input  logic [SIDE-1:0]          i_ctr_word,
    input  logic [SIDE-1:0]          i_up_word,
    input  logic [SIDE-1:0]          i_dn_word,
    input  logic [$clog2(SIDE)-1:0]  i_col,
    input  logic [RND_W-1:0]         i_rnd,
    input  logic [RND_W-1:0]         i_lvl4,
    input  logic [RND_W-1:0]         i_lvl8,
    output logic                     o_spin_old,
    output logic                     o_flip,
    output logic [SIDE-1:0]          o_new_word
);

    localparam int COL_W = $clog2(SIDE);

    logic [COL_W-1:0] lf_col;
    logic [COL_W-1:0] rt_col;
    logic             s;
    logic [2:0]       same_cnt;

    assign lf_col = (i_col == '0) ? COL_W'(SIDE - 1) : i_col - COL_W'(1);
    assign rt_col = (i_col == COL_W'(SIDE - 1)) ? '0 : i_col + COL_W'(1);
    assign s      = i_ctr_word[i_col];

    // dE = 4 * same_cnt - 8
    assign same_cnt = 3'(i_up_word[i_col] == s) + 3'(i_dn_word[i_col] == s)
                    + 3'(i_ctr_word[lf_col] == s) + 3'(i_ctr_word[rt_col] == s);

    always_comb begin
        case (same_cnt) inside
            [3'd0:3'd2]: o_flip = 1'b1;
            3'd3:        o_flip = (i_rnd <= i_lvl4);
            3'd4:        o_flip = (i_rnd <= i_lvl8);
            default:     o_flip = 1'b1;
        endcase
    end

    always_comb begin
        o_new_word        = i_ctr_word;
        o_new_word[i_col] = s ^ o_flip;
    end

    assign o_spin_old = s;

endmodule
